// ===== design/rlt_pkg.sv =====
// shared types and constants for the resource lifetime tracker
package rlt_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_DESTROY = 3'd2;
    localparam logic [2:0] OP_ACCESS  = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_INTERVAL  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_BUDGET    = 2'd3;

    localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IDLE_MAX  = 32'hFFFF_FFFF;
    localparam logic [6:0]  LEAK_MAX  = 7'd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_APPLY,
        ST_COUNT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] resource_id;
        logic [2:0]  resource_type;
        logic [47:0] size_bytes;
        logic [15:0] elapsed_ms;
    } req_t;

    typedef struct packed {
        logic        entry_found;
        logic        table_full;
        logic        over_budget;
        logic        scan_done;
        logic [47:0] live_bytes;
        logic [47:0] peak_bytes;
        logic [6:0]  suspected_leaks;
        logic [31:0] type_allocs;
        logic [31:0] type_frees;
        logic [31:0] type_outstanding;
        logic [31:0] total_allocs;
        logic [31:0] total_frees;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear walk index
        logic step;      // one table entry per cycle
        logic apply;     // commit create/destroy/access/tick totals
        logic count;     // one per-type counter per cycle
        logic publish;   // load output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_last;
        logic count_last;
    } sts_t;

endpackage

// ===== design/rlt_if.sv =====
// valid/ready channel carrying one payload
interface rlt_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rlt_cfg_if.sv =====
// configuration write channel
interface rlt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== design/rlt_ctrl.sv =====
// sequencer: walk the table, apply the result, sum counters, publish
module rlt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_free,
    input  rlt_pkg::sts_t   sts,
    output rlt_pkg::cmd_t   cmd,
    output logic            busy
);
    rlt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rlt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlt_pkg::ST_IDLE:  if (in_fire) state_next = rlt_pkg::ST_WALK;
            rlt_pkg::ST_WALK:  if (sts.walk_last) state_next = rlt_pkg::ST_APPLY;
            rlt_pkg::ST_APPLY: state_next = rlt_pkg::ST_COUNT;
            rlt_pkg::ST_COUNT: if (sts.count_last) state_next = rlt_pkg::ST_DONE;
            rlt_pkg::ST_DONE:  if (out_free) state_next = rlt_pkg::ST_IDLE;
            default:           state_next = rlt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            rlt_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = in_fire;
            end
            rlt_pkg::ST_WALK:  cmd.step = 1'b1;
            rlt_pkg::ST_APPLY: cmd.apply = 1'b1;
            rlt_pkg::ST_COUNT: cmd.count = 1'b1;
            rlt_pkg::ST_DONE:  cmd.publish = out_free;
            default:           cmd = '0;
        endcase
    end
endmodule

// ===== design/rlt_dp.sv =====
// table, counters and arithmetic
module rlt_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int TYPE_COUNT  = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rlt_pkg::cmd_t   cmd,
    input  rlt_pkg::req_t   req,
    input  logic            en,
    input  logic [15:0]     interval,
    input  logic [31:0]     threshold,
    input  logic [47:0]     budget,
    output rlt_pkg::sts_t   sts,
    output rlt_pkg::rsp_t   rsp
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

    rlt_pkg::req_t req_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [63:0] key_mem  [TABLE_DEPTH];
    logic [47:0] size_mem [TABLE_DEPTH];
    logic [31:0] idle_mem [TABLE_DEPTH];

    logic [31:0] allocs_reg [TYPE_COUNT];
    logic [31:0] frees_reg  [TYPE_COUNT];

    logic [47:0] total_reg, peak_reg;
    logic [15:0] phase_reg;
    logic [6:0]  leak_reg;

    logic [IW:0] idx_reg;
    logic [IW-1:0] idx;
    logic        hit_reg, free_ok_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [47:0] hit_size_reg;
    logic [6:0]  leaks_acc_reg;
    logic        scan_reg;
    logic        found_reg, full_reg, over_reg;

    // registered read of the entry fetched in the previous walk cycle
    logic          rd_ok_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [63:0]   rd_key_reg;
    logic [47:0]   rd_size_reg;
    logic [31:0]   rd_idle_reg;
    logic          rd_live, rd_hit;

    logic [TW:0] cidx_reg;
    logic [31:0] sum_a_reg, sum_f_reg;

    logic is_tick, is_create, is_destroy, is_access, type_ok;
    logic [15:0] phase_inc;
    logic [32:0] idle_sum;
    logic [31:0] idle_new;
    logic [48:0] add_sum;
    logic [47:0] total_add;
    logic [IW-1:0] slot;
    logic [TW-1:0] tsel;

    assign idx        = idx_reg[IW-1:0];
    assign is_tick    = (req_reg.operation == rlt_pkg::OP_TICK) && en;
    assign is_create  = (req_reg.operation == rlt_pkg::OP_CREATE) && en;
    assign is_destroy = (req_reg.operation == rlt_pkg::OP_DESTROY);
    assign is_access  = (req_reg.operation == rlt_pkg::OP_ACCESS);
    assign type_ok    = ({29'd0, req_reg.resource_type} < TYPE_COUNT);
    assign tsel       = req_reg.resource_type[TW-1:0];
    assign phase_inc  = phase_reg + 16'd1;
    assign rd_live    = rd_ok_reg && valid_reg[rd_idx_reg];
    assign rd_hit     = rd_live && (rd_key_reg == req_reg.resource_id);
    assign idle_sum   = {1'b0, rd_idle_reg} + {17'd0, req_reg.elapsed_ms};
    assign idle_new   = idle_sum[32] ? rlt_pkg::IDLE_MAX : idle_sum[31:0];
    assign add_sum    = {1'b0, total_reg} + {1'b0, req_reg.size_bytes};
    assign total_add  = add_sum[48] ? rlt_pkg::BYTES_MAX : add_sum[47:0];
    assign slot       = hit_reg ? hit_idx_reg : free_idx_reg;

    // last walk cycle evaluates the entry read in the previous walk cycle
    assign sts.walk_last  = (idx_reg == (IW + 1)'(TABLE_DEPTH));
    assign sts.count_last = (cidx_reg == (TW + 1)'(TYPE_COUNT - 1));

    // tick adds elapsed time entry by entry during the walk; scan counts with
    // the updated value
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.step)
        begin
            rd_key_reg  <= key_mem[idx];
            rd_size_reg <= size_mem[idx];
            rd_idle_reg <= idle_mem[idx];
        end
        if (cmd.step && is_tick && rd_live)
            idle_mem[rd_idx_reg] <= idle_new;
        if (cmd.apply && is_create && (hit_reg || free_ok_reg))
        begin
            key_mem[slot]  <= req_reg.resource_id;
            size_mem[slot] <= req_reg.size_bytes;
            idle_mem[slot] <= '0;
        end
        if (cmd.apply && is_access && hit_reg)
            idle_mem[hit_idx_reg] <= '0;
        if (cmd.step && rd_hit && !hit_reg)
            hit_size_reg <= rd_size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            allocs_reg    <= '{default: '0};
            frees_reg     <= '{default: '0};
            total_reg     <= '0;
            peak_reg      <= '0;
            phase_reg     <= '0;
            leak_reg      <= '0;
            idx_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            free_ok_reg   <= 1'b0;
            hit_idx_reg   <= '0;
            free_idx_reg  <= '0;
            leaks_acc_reg <= '0;
            scan_reg      <= 1'b0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            over_reg      <= 1'b0;
            cidx_reg      <= '0;
            sum_a_reg     <= '0;
            sum_f_reg     <= '0;
            rsp           <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg       <= '0;
                rd_ok_reg     <= 1'b0;
                hit_reg       <= 1'b0;
                free_ok_reg   <= 1'b0;
                leaks_acc_reg <= '0;
                scan_reg      <= 1'b0;
                found_reg     <= 1'b0;
                full_reg      <= 1'b0;
                over_reg      <= 1'b0;
                cidx_reg      <= '0;
                sum_a_reg     <= '0;
                sum_f_reg     <= '0;
            end
            if (cmd.step)
            begin
                idx_reg    <= idx_reg + 1'b1;
                rd_ok_reg  <= !sts.walk_last;
                rd_idx_reg <= idx;
                if (rd_hit && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
                if (rd_ok_reg && !valid_reg[rd_idx_reg] && !free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if (rd_live && idle_new >= threshold && leaks_acc_reg != rlt_pkg::LEAK_MAX)
                    leaks_acc_reg <= leaks_acc_reg + 7'd1;
            end
            if (cmd.apply)
            begin
                if (is_tick)
                begin
                    if (phase_inc >= interval)
                    begin
                        phase_reg <= '0;
                        leak_reg  <= leaks_acc_reg;
                        scan_reg  <= 1'b1;
                    end
                    else
                        phase_reg <= phase_inc;
                end
                else if (is_create)
                begin
                    if (hit_reg || free_ok_reg)
                    begin
                        valid_reg[slot] <= 1'b1;
                        if (type_ok)
                            allocs_reg[tsel] <= allocs_reg[tsel] + 32'd1;
                        total_reg <= total_add;
                        if (total_add > peak_reg)
                            peak_reg <= total_add;
                        over_reg <= (total_add > budget);
                    end
                    else
                        full_reg <= 1'b1;
                end
                else if (is_destroy && hit_reg)
                begin
                    found_reg <= 1'b1;
                    valid_reg[hit_idx_reg] <= 1'b0;
                    if (type_ok)
                        frees_reg[tsel] <= frees_reg[tsel] + 32'd1;
                    total_reg <= (total_reg >= hit_size_reg) ? total_reg - hit_size_reg : '0;
                end
                else if (is_access && hit_reg)
                    found_reg <= 1'b1;
            end
            if (cmd.count)
            begin
                cidx_reg  <= cidx_reg + 1'b1;
                sum_a_reg <= sum_a_reg + allocs_reg[cidx_reg[TW-1:0]];
                sum_f_reg <= sum_f_reg + frees_reg[cidx_reg[TW-1:0]];
            end
            if (cmd.publish)
            begin
                rsp.entry_found      <= found_reg;
                rsp.table_full       <= full_reg;
                rsp.over_budget      <= over_reg;
                rsp.scan_done        <= scan_reg;
                rsp.live_bytes       <= total_reg;
                rsp.peak_bytes       <= peak_reg;
                rsp.suspected_leaks  <= leak_reg;
                rsp.type_allocs      <= type_ok ? allocs_reg[tsel] : '0;
                rsp.type_frees       <= type_ok ? frees_reg[tsel] : '0;
                rsp.type_outstanding <= type_ok ? allocs_reg[tsel] - frees_reg[tsel] : '0;
                rsp.total_allocs     <= sum_a_reg;
                rsp.total_frees      <= sum_f_reg;
            end
        end
    end
endmodule

// ===== design/resource_lifetime_tracker.sv =====
// top level of the resource lifetime tracker
// A transaction is accepted only while the controller is idle, so the next one
// waits until the previous result has been published. The controller walks the
// allocation table one entry per cycle with a registered table read (key
// match, free entry search, idle timer update and leak count in one pass),
// commits the result, then sums the per-type counters one type per cycle
// before loading the output register. A finished result sits in that
// register until taken; the next transaction may be accepted and walked
// while it waits, and is held at the output stage only until the register
// frees up.
// No clearing pass after reset: entries carry valid bits cleared at once.
module resource_lifetime_tracker #(
    parameter int TABLE_DEPTH = 64,
    parameter int TYPE_COUNT  = 6
) (
    input  logic      clk,
    input  logic      rst_n,
    rlt_if.sink       req,
    rlt_if.source     rsp,
    rlt_cfg_if.sink   cfg
);
    // configuration registers
    logic        enable_reg;
    logic [15:0] interval_reg;
    logic [31:0] threshold_reg;
    logic [47:0] budget_reg;

    logic          out_valid_reg;
    logic          busy;
    logic          in_fire;
    logic          out_free;
    rlt_pkg::cmd_t cmd;
    rlt_pkg::sts_t sts;
    rlt_pkg::rsp_t rsp_data;

    assign cfg.ready = 1'b1;
    assign req.ready = !busy;
    assign in_fire   = req.valid && req.ready;
    // output register is free when empty or taken this cycle
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            interval_reg  <= 16'd60;
            threshold_reg <= 32'd30000;
            budget_reg    <= 48'd536870912;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    rlt_pkg::CFG_ENABLE:    enable_reg    <= cfg.wdata[0];
                    rlt_pkg::CFG_INTERVAL:  interval_reg  <= cfg.wdata[15:0];
                    rlt_pkg::CFG_THRESHOLD: threshold_reg <= cfg.wdata[31:0];
                    rlt_pkg::CFG_BUDGET:    budget_reg    <= cfg.wdata;
                    default:                enable_reg    <= enable_reg;
                endcase
            end
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    rlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    rlt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TYPE_COUNT  (TYPE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req.data),
        .en        (enable_reg),
        .interval  (interval_reg),
        .threshold (threshold_reg),
        .budget    (budget_reg),
        .sts       (sts),
        .rsp       (rsp_data)
    );
endmodule

// ===== design/rlt_checker.sv =====
// port-level checks for the resource lifetime tracker
module rlt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input rlt_pkg::rsp_t rsp_data
);
    // one transaction at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready) else $error("accept while busy");

    // a result follows an accept only after the table walk
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
        else $error("result too early");

    // a result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("result dropped");

    // peak never below live total
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.peak_bytes >= rsp_data.live_bytes))
        else $error("peak below live");
endmodule

bind resource_lifetime_tracker rlt_checker u_rlt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== dv/resource_lifetime_tracker_tb.sv =====
`timescale 1ns / 1ps
// testbench for the resource lifetime tracker: directed table, random traffic, predictor check
module resource_lifetime_tracker_tb;

    localparam int DEPTH = 64;
    localparam int NTYPES = 6;
    localparam int ID_POOL = 96;

    // one row of the directed table; typed rows carry their own expected response
    typedef struct {
        rlt_pkg::req_t txn;
        bit            typed;
        rlt_pkg::rsp_t rsp;
    } row_t;

    logic clk;
    logic rst_n;

    rlt_if #(.T(rlt_pkg::req_t)) req_ch ();
    rlt_if #(.T(rlt_pkg::rsp_t)) rsp_ch ();
    rlt_cfg_if                   cfg_ch ();

    resource_lifetime_tracker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // mirror of the tracker state
    bit          live_valid [DEPTH];
    logic [63:0] live_key [DEPTH];
    logic [47:0] live_size [DEPTH];
    logic [31:0] live_idle [DEPTH];
    logic [31:0] allocs_by_type [NTYPES];
    logic [31:0] frees_by_type [NTYPES];
    logic [47:0] bytes_now;
    logic [47:0] bytes_high;
    logic [15:0] ticks_since_scan;
    logic [6:0]  leaks_seen;

    // mirror of the registers
    logic        track_on;
    logic [15:0] scan_every;
    logic [31:0] leak_after_ms;
    logic [47:0] byte_budget;

    rlt_pkg::rsp_t pending_rsp [$];
    logic [63:0]   id_pool [ID_POOL];
    int            mismatches;
    bit            calm;

    // clock: 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // hard limit on the run
    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    // compute one response and update the mirrored state
    function automatic rlt_pkg::rsp_t track_step(rlt_pkg::req_t t);
        rlt_pkg::rsp_t r;
        int            hit;
        int            slot;
        logic [48:0]   sum;
        logic [32:0]   idle;
        int            n;
        r = '0;
        if (t.operation == rlt_pkg::OP_TICK && track_on)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (live_valid[i])
                begin
                    idle = {1'b0, live_idle[i]} + {17'd0, t.elapsed_ms};
                    live_idle[i] = idle[32] ? rlt_pkg::IDLE_MAX : idle[31:0];
                end
            end
            ticks_since_scan = ticks_since_scan + 16'd1;
            if (ticks_since_scan >= scan_every)
            begin
                ticks_since_scan = '0;
                n = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (live_valid[i] && live_idle[i] >= leak_after_ms && n < 127)
                        n++;
                leaks_seen = n[6:0];
                r.scan_done = 1'b1;
            end
        end
        else if (t.operation == rlt_pkg::OP_CREATE && track_on)
        begin
            hit = -1;
            for (int i = 0; i < DEPTH; i++)
                if (hit < 0 && live_valid[i] && live_key[i] == t.resource_id)
                    hit = i;
            slot = hit;
            for (int i = 0; i < DEPTH; i++)
                if (slot < 0 && !live_valid[i])
                    slot = i;
            if (slot < 0)
                r.table_full = 1'b1;
            else
            begin
                if (t.resource_type < NTYPES)
                    allocs_by_type[t.resource_type]++;
                live_valid[slot] = 1'b1;
                live_key[slot] = t.resource_id;
                live_size[slot] = t.size_bytes;
                live_idle[slot] = '0;
                sum = {1'b0, bytes_now} + {1'b0, t.size_bytes};
                bytes_now = sum[48] ? rlt_pkg::BYTES_MAX : sum[47:0];
                if (bytes_now > bytes_high)
                    bytes_high = bytes_now;
                r.over_budget = bytes_now > byte_budget;
            end
        end
        else if (t.operation == rlt_pkg::OP_DESTROY || t.operation == rlt_pkg::OP_ACCESS)
        begin
            hit = -1;
            for (int i = 0; i < DEPTH; i++)
                if (hit < 0 && live_valid[i] && live_key[i] == t.resource_id)
                    hit = i;
            if (hit >= 0)
            begin
                r.entry_found = 1'b1;
                if (t.operation == rlt_pkg::OP_ACCESS)
                    live_idle[hit] = '0;
                else
                begin
                    if (t.resource_type < NTYPES)
                        frees_by_type[t.resource_type]++;
                    // floor at zero when the entry is larger than the total
                    bytes_now = (bytes_now >= live_size[hit]) ? bytes_now - live_size[hit] : '0;
                    live_valid[hit] = 1'b0;
                end
            end
        end
        for (int i = 0; i < NTYPES; i++)
        begin
            r.total_allocs += allocs_by_type[i];
            r.total_frees += frees_by_type[i];
        end
        if (t.resource_type < NTYPES)
        begin
            r.type_allocs = allocs_by_type[t.resource_type];
            r.type_frees = frees_by_type[t.resource_type];
        end
        r.type_outstanding = r.type_allocs - r.type_frees;
        r.live_bytes = bytes_now;
        r.peak_bytes = bytes_high;
        r.suspected_leaks = leaks_seen;
        return r;
    endfunction

    // offer one transaction, with an occasional idle burst first
    task automatic send_txn(rlt_pkg::req_t t, bit typed, rlt_pkg::rsp_t typed_rsp);
        rlt_pkg::rsp_t predicted;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = t;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = track_step(t);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic stop_offering();
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic wait_idle();
        wait (pending_rsp.size() == 0);
        repeat (90) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.wdata = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            rlt_pkg::CFG_ENABLE:    track_on = val[0];
            rlt_pkg::CFG_INTERVAL:  scan_every = val[15:0];
            rlt_pkg::CFG_THRESHOLD: leak_after_ms = val[31:0];
            rlt_pkg::CFG_BUDGET:    byte_budget = val;
            default:                ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_regs(bit en, logic [15:0] every, logic [31:0] thr, logic [47:0] budget);
        write_reg(rlt_pkg::CFG_ENABLE, {47'd0, en});
        write_reg(rlt_pkg::CFG_INTERVAL, {32'd0, every});
        write_reg(rlt_pkg::CFG_THRESHOLD, {16'd0, thr});
        write_reg(rlt_pkg::CFG_BUDGET, budget);
    endtask

    // random transaction; create_pct steers how fast the table fills
    function automatic rlt_pkg::req_t random_txn(int create_pct);
        rlt_pkg::req_t t;
        int            pick;
        t.resource_id = $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                                  : id_pool[$urandom_range(0, ID_POOL - 1)];
        t.resource_type = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       t.size_bytes = 48'({$urandom, $urandom});
            1:       t.size_bytes = rlt_pkg::BYTES_MAX - 48'($urandom_range(0, 3));
            default: t.size_bytes = 48'($urandom_range(0, 65536));
        endcase
        t.elapsed_ms = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
        pick = $urandom_range(0, 99);
        if (pick < create_pct)
            t.operation = rlt_pkg::OP_CREATE;
        else if (pick < create_pct + 20)
            t.operation = rlt_pkg::OP_DESTROY;
        else if (pick < create_pct + 32)
            t.operation = rlt_pkg::OP_ACCESS;
        else if (pick < create_pct + 52)
            t.operation = rlt_pkg::OP_TICK;
        else if (pick < 95)
            t.operation = rlt_pkg::OP_QUERY;
        else
            t.operation = 3'($urandom_range(5, 7));
        return t;
    endfunction

    task automatic random_run(int count, int create_pct);
        for (int i = 0; i < count; i++)
            send_txn(random_txn(create_pct), 1'b0, '0);
        stop_offering();
    endtask

    // response side: ready in random bursts, always high once calm
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                rsp_ch.ready = 1'b1;
            else if ($urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge clk);
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // compare every accepted response with the oldest expectation
    always @(posedge clk)
    begin
        rlt_pkg::rsp_t e;
        rlt_pkg::rsp_t a;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            a = rsp_ch.data;
            if (pending_rsp.size() == 0)
            begin
                $error("response transaction with nothing expected");
                mismatches++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                check_field("entry_found", 64'(e.entry_found), 64'(a.entry_found));
                check_field("table_full", 64'(e.table_full), 64'(a.table_full));
                check_field("over_budget", 64'(e.over_budget), 64'(a.over_budget));
                check_field("scan_done", 64'(e.scan_done), 64'(a.scan_done));
                check_field("live_bytes", 64'(e.live_bytes), 64'(a.live_bytes));
                check_field("peak_bytes", 64'(e.peak_bytes), 64'(a.peak_bytes));
                check_field("suspected_leaks", 64'(e.suspected_leaks),
                            64'(a.suspected_leaks));
                check_field("type_allocs", 64'(e.type_allocs), 64'(a.type_allocs));
                check_field("type_frees", 64'(e.type_frees), 64'(a.type_frees));
                check_field("type_outstanding", 64'(e.type_outstanding),
                            64'(a.type_outstanding));
                check_field("total_allocs", 64'(e.total_allocs), 64'(a.total_allocs));
                check_field("total_frees", 64'(e.total_frees), 64'(a.total_frees));
            end
        end
    end

    initial
    begin
        row_t          rows [$];
        row_t          w;
        rlt_pkg::rsp_t z;

        mismatches = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = rlt_pkg::CFG_ENABLE;
        cfg_ch.wdata = '0;
        for (int i = 0; i < ID_POOL; i++)
            id_pool[i] = {$urandom, $urandom};

        // reset values of the mirror
        for (int i = 0; i < DEPTH; i++)
        begin
            live_valid[i] = 1'b0;
            live_key[i] = '0;
            live_size[i] = '0;
            live_idle[i] = '0;
        end
        for (int i = 0; i < NTYPES; i++)
        begin
            allocs_by_type[i] = '0;
            frees_by_type[i] = '0;
        end
        bytes_now = '0;
        bytes_high = '0;
        ticks_since_scan = '0;
        leaks_seen = '0;
        track_on = 1'b1;
        scan_every = 16'd60;
        leak_after_ms = 32'd30000;
        byte_budget = 48'd536870912;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; counters all zero straight after reset
        z = '0;
        w.typed = 1'b1;
        w.rsp = z;
        w.txn = '{operation: rlt_pkg::OP_QUERY, resource_id: '0, resource_type: 3'd0,
                  size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_DESTROY, resource_id: '0, resource_type: 3'd5,
                  size_bytes: rlt_pkg::BYTES_MAX, elapsed_ms: 16'hFFFF};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_ACCESS, resource_id: '1, resource_type: 3'd7,
                  size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        // largest create with an uncounted type: full bytes, over budget
        w.txn = '{operation: rlt_pkg::OP_CREATE, resource_id: '0, resource_type: 3'd7,
                  size_bytes: rlt_pkg::BYTES_MAX, elapsed_ms: '0};
        w.rsp = z;
        w.rsp.over_budget = 1'b1;
        w.rsp.live_bytes = rlt_pkg::BYTES_MAX;
        w.rsp.peak_bytes = rlt_pkg::BYTES_MAX;
        rows.push_back(w);
        w.typed = 1'b0;
        // saturating add, re-create of a live id, then frees below zero
        w.txn = '{operation: rlt_pkg::OP_CREATE, resource_id: '1, resource_type: 3'd0,
                  size_bytes: 48'd5, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_CREATE, resource_id: '1, resource_type: 3'd5,
                  size_bytes: 48'd9, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_DESTROY, resource_id: '0, resource_type: 3'd0,
                  size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_DESTROY, resource_id: '1, resource_type: 3'd5,
                  size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_CREATE, resource_id: 64'h8000_0000_0000_0001,
                  resource_type: 3'd6, size_bytes: 48'd100, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_TICK, resource_id: '1, resource_type: 3'd6,
                  size_bytes: '0, elapsed_ms: 16'hFFFF};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_TICK, resource_id: '0, resource_type: 3'd1,
                  size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        w.txn = '{operation: rlt_pkg::OP_ACCESS, resource_id: 64'h8000_0000_0000_0001,
                  resource_type: 3'd2, size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        for (int op = 5; op < 8; op++)
        begin
            w.txn = '{operation: 3'(op), resource_id: '1, resource_type: 3'd1,
                      size_bytes: rlt_pkg::BYTES_MAX, elapsed_ms: 16'hFFFF};
            rows.push_back(w);
        end
        w.txn = '{operation: rlt_pkg::OP_QUERY, resource_id: '0, resource_type: 3'd6,
                  size_bytes: '0, elapsed_ms: '0};
        rows.push_back(w);
        foreach (rows[i])
            send_txn(rows[i].txn, rows[i].typed, rows[i].rsp);
        stop_offering();

        // default registers
        random_run(300, 30);
        wait_idle();

        // scan on every tick, everything counts as leaked, any byte is over budget
        set_regs(1'b1, 16'd1, 32'd0, 48'd0);
        random_run(300, 30);
        wait_idle();

        // widest interval and threshold, largest budget
        set_regs(1'b1, 16'hFFFF, rlt_pkg::IDLE_MAX, rlt_pkg::BYTES_MAX);
        random_run(250, 30);
        wait_idle();

        // tracking off: creates and ticks are ignored
        write_reg(rlt_pkg::CFG_ENABLE, 48'd0);
        random_run(150, 30);
        wait_idle();

        // create-heavy traffic fills the table and hits the full case
        set_regs(1'b1, 16'd3, 32'd4000, 48'd1 << 20);
        random_run(400, 55);
        wait_idle();

        // interval zero scans on every tick; no idling from here on
        calm = 1'b1;
        set_regs(1'b1, 16'd0, 32'd1500, 48'd123456);
        random_run(430, 30);

        wait (pending_rsp.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
